@@ rtl/notch_filter_jitter_histogram_unit_assert.svh @@
// Assertion macros shared by the notch filter jitter histogram RTL
`ifndef NOTCH_FILTER_JITTER_HISTOGRAM_UNIT_ASSERT_SVH
`define NOTCH_FILTER_JITTER_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define NFJH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define NFJH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nfjh_pkg.sv @@
// Shared widths, filter coefficients and stage types
package nfjh_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TS_W     = 32;
  localparam int DATA_W   = 32;
  localparam int JIT_W    = 30;
  localparam int JB_W     = 6;

  localparam logic [TS_W-1:0] PERIOD_RST = 32'd40000;

  // Notch biquad taps: y = (256(x0+x2) - 503x1 + 498y1 - 251y2 + 128) / 256
  localparam logic [DATA_W-1:0] COEF_X1  = 32'd503;
  localparam logic [DATA_W-1:0] COEF_Y1  = 32'd498;
  localparam logic [DATA_W-1:0] COEF_Y2  = 32'd251;
  localparam logic [DATA_W-1:0] ROUND_K  = 32'd128;
  localparam logic [DATA_W-1:0] TRUNC_K  = 32'd255;
  localparam int                Y_SHIFT  = 8;

  // Jitter rounding: (dev + 4) / 8
  localparam logic [TS_W:0] JIT_ROUND = 33'd4;
  localparam int            JIT_SHIFT = 3;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered;
    logic                     jitter_valid;
    logic [JIT_W-1:0]         max_jitter;
  } front_item_t;

endpackage

@@ rtl/nfjh_if.sv @@
// Stream interfaces: sample input, result output and period write channel
interface nfjh_in_if;
  import nfjh_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [TS_W-1:0]     timestamp;
  logic                run_active;
  modport source (output valid, output sample, output timestamp, output run_active,
                  input ready);
  modport sink   (input valid, input sample, input timestamp, input run_active,
                  output ready);
endinterface

interface nfjh_out_if;
  import nfjh_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered;
  logic                     jitter_valid;
  logic [JB_W-1:0]          jitter_bin;
  logic [DATA_W-1:0]        bin_count;
  logic [JIT_W-1:0]         max_jitter_out;
  modport source (output valid, output filtered, output jitter_valid, output jitter_bin,
                  output bin_count, output max_jitter_out, input ready);
  modport sink   (input valid, input filtered, input jitter_valid, input jitter_bin,
                  input bin_count, input max_jitter_out, output ready);
endinterface

interface nfjh_cfg_if;
  import nfjh_pkg::*;
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/notch_filter_jitter_histogram_unit.sv @@
// Top level: notch filter and sampling-jitter histogram, one channel
// Takes one sample beat per clock unless stalled or clearing, and returns one result
// beat per beat with run_active set, via the histogram stage and output registers;
// beats with run_active clear are taken and dropped. The rate is set by the histogram
// update: a read of the bin's count from a RAM with a registered read, an increment
// and a write back, with the value forwarded when back-to-back beats hit the same bin.
// After reset the histogram RAM is cleared one bin per cycle, and no sample is taken
// until the sweep ends; period writes are taken at any time. A stalled result holds in
// the output register while one further beat is taken into the histogram stage.
module notch_filter_jitter_histogram_unit #(
  parameter int HIST_BINS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  nfjh_in_if.sink     in_ch,
  nfjh_out_if.source  out_ch,
  nfjh_cfg_if.sink    cfg_ch
);
  import nfjh_pkg::*;

  localparam int BW = $clog2(HIST_BINS);

  logic            period_wr;
  logic [TS_W-1:0] period_r;
  logic            in_ready, step;
  front_item_t     item;
  logic [BW-1:0]   bin;

  assign cfg_ch.ready = 1'b1;
  assign period_wr    = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
    end else if (period_wr) begin
      period_r <= cfg_ch.data;
    end
  end

  assign in_ch.ready = in_ready;
  assign step        = in_ch.valid && in_ready && in_ch.run_active;

  nfjh_front #(
    .HIST_BINS (HIST_BINS),
    .BW        (BW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .sample    (in_ch.sample),
    .timestamp (in_ch.timestamp),
    .period    (period_r),
    .item      (item),
    .bin       (bin)
  );

  nfjh_hist #(
    .HIST_BINS (HIST_BINS),
    .BW        (BW)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (item),
    .bin      (bin),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

endmodule

@@ rtl/nfjh_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port
module nfjh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ rtl/nfjh_front.sv @@
// Front stage: notch biquad with feedback registers and timestamp jitter
module nfjh_front #(
  parameter int HIST_BINS = 64,
  parameter int BW        = $clog2(HIST_BINS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [nfjh_pkg::SAMPLE_W-1:0] sample,
  input  logic [nfjh_pkg::TS_W-1:0]     timestamp,
  input  logic [nfjh_pkg::TS_W-1:0]     period,
  output nfjh_pkg::front_item_t         item,
  output logic [BW-1:0]                 bin
);
  import nfjh_pkg::*;

  logic [SAMPLE_W-1:0] x1_r, x2_r;
  logic [DATA_W-1:0]   y1_r, y2_r;
  logic [TS_W-1:0]     prev_r;
  logic                first_r;
  logic [JIT_W-1:0]    max_r, max_nxt;

  logic [DATA_W-1:0] acc, acc_adj, y0;
  logic [TS_W-1:0]   diff, dev;
  logic [TS_W:0]     dev_rnd;
  logic [JIT_W-1:0]  jit;

  always_comb begin
    acc = ((DATA_W'(sample) + DATA_W'(x2_r)) << Y_SHIFT)
        - COEF_X1 * DATA_W'(x1_r)
        + COEF_Y1 * y1_r
        - COEF_Y2 * y2_r
        + ROUND_K;
    // truncate toward zero on negative numerators
    acc_adj = acc + (acc[DATA_W-1] ? TRUNC_K : '0);
    y0      = DATA_W'($signed(acc_adj) >>> Y_SHIFT);
  end

  always_comb begin
    diff    = timestamp - prev_r;
    dev     = (diff > period) ? (diff - period) : (period - diff);
    dev_rnd = ({1'b0, dev} + JIT_ROUND) >> JIT_SHIFT;
    jit     = dev_rnd[JIT_W-1:0];
    max_nxt = (first_r && (jit > max_r)) ? jit : max_r;
    bin     = (jit >= JIT_W'(HIST_BINS)) ? BW'(HIST_BINS - 1) : jit[BW-1:0];
  end

  assign item.filtered     = $signed(y0);
  assign item.jitter_valid = first_r;
  assign item.max_jitter   = max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r    <= '0;
      x2_r    <= '0;
      y1_r    <= '0;
      y2_r    <= '0;
      prev_r  <= '0;
      first_r <= 1'b0;
      max_r   <= '0;
    end else if (step) begin
      x2_r    <= x1_r;
      x1_r    <= sample;
      y2_r    <= y1_r;
      y1_r    <= y0;
      prev_r  <= timestamp;
      first_r <= 1'b1;
      max_r   <= max_nxt;
    end
  end

endmodule

@@ rtl/nfjh_hist.sv @@
// Histogram read-modify-write stage with forwarding, clear sweep and output register
`include "notch_filter_jitter_histogram_unit_assert.svh"

module nfjh_hist #(
  parameter int HIST_BINS = 64,
  parameter int BW        = $clog2(HIST_BINS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  nfjh_pkg::front_item_t item,
  input  logic [BW-1:0]         bin,
  output logic                  in_ready,
  nfjh_out_if.source            out_ch
);
  import nfjh_pkg::*;

  logic              clearing_r;
  logic [BW-1:0]     clr_cnt_r;

  logic              s1_v_r;
  front_item_t       s1_item_r;
  logic [BW-1:0]     s1_bin_r;
  logic              fwd_r;
  logic [DATA_W-1:0] fwd_val_r;

  logic              out_v_r;
  logic signed [DATA_W-1:0] out_filt_r;
  logic              out_jv_r;
  logic [JB_W-1:0]   out_bin_r;
  logic [DATA_W-1:0] out_cnt_r;
  logic [JIT_W-1:0]  out_max_r;

  logic              s1_adv, hit, we;
  logic [DATA_W-1:0] rd_data, new_count, wdata;
  logic [BW-1:0]     waddr;
  logic [BW+JB_W-1:0] bin_ext;

  assign s1_adv    = !out_v_r || out_ch.ready;
  assign in_ready  = !clearing_r && (!s1_v_r || s1_adv);
  assign new_count = (fwd_r ? fwd_val_r : rd_data) + 1'b1;
  // the bin written this cycle is the one a new beat reads: pass it along
  assign hit       = s1_v_r && s1_adv && s1_item_r.jitter_valid && (s1_bin_r == bin);
  assign we        = clearing_r || (s1_v_r && s1_adv && s1_item_r.jitter_valid);
  assign waddr     = clearing_r ? clr_cnt_r : s1_bin_r;
  assign wdata     = clearing_r ? '0 : new_count;
  assign bin_ext   = {{JB_W{1'b0}}, s1_bin_r};

  nfjh_ram #(
    .WIDTH (DATA_W),
    .DEPTH (HIST_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (step),
    .raddr (bin),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == BW'(HIST_BINS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (step) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_item_r <= item;
      s1_bin_r  <= bin;
      fwd_r     <= hit;
      fwd_val_r <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_filt_r <= s1_item_r.filtered;
      out_jv_r   <= s1_item_r.jitter_valid;
      out_bin_r  <= s1_item_r.jitter_valid ? bin_ext[JB_W-1:0] : '0;
      out_cnt_r  <= s1_item_r.jitter_valid ? new_count : '0;
      out_max_r  <= s1_item_r.max_jitter;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.filtered       = out_filt_r;
  assign out_ch.jitter_valid   = out_jv_r;
  assign out_ch.jitter_bin     = out_bin_r;
  assign out_ch.bin_count      = out_cnt_r;
  assign out_ch.max_jitter_out = out_max_r;

  `NFJH_ASSERT_IMP(a_no_take_while_clearing, clearing_r, !in_ready,
                   "beat taken during histogram clear")
  `NFJH_ASSERT_NXT(a_s1_held_on_stall, s1_v_r && !s1_adv, s1_v_r,
                   "stalled histogram stage lost its beat")
  `NFJH_ASSERT_IMP(a_out_from_s1, $rose(out_v_r), $past(s1_v_r),
                   "result appeared without a stage beat")
  `NFJH_ASSERT_NXT(a_fwd_needs_write, step && hit, fwd_r,
                   "forward flag missed a same-bin update")

endmodule
